### design/paged_translation_with_replacement_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the page translation block
// ---------------------------------------------------------------------------
`ifndef PAGED_TRANSLATION_WITH_REPLACEMENT_ASSERT_SVH
`define PAGED_TRANSLATION_WITH_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define PTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ptr_pkg.sv
// ---------------------------------------------------------------------------
// ptr_pkg
// Types, constants and sequencer codes of the paged translation block.
// ---------------------------------------------------------------------------
package ptr_pkg;

  localparam int NUM_PAGES  = 1024;
  localparam int NUM_FRAMES = 64;
  localparam int PAGE_W     = 10;
  localparam int FRAME_W    = 6;
  localparam int LINK_W     = 7;
  localparam int CNT_W      = 7;   // holds 0..NUM_FRAMES
  localparam int PCNT_W     = 11;  // holds 0..NUM_PAGES
  localparam int NU_W       = 32;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;
  localparam logic [NU_W-1:0]   NEVER_USE = '1;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;
  localparam logic [1:0] POL_OPT   = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_PAGES  = 2'd2;
  localparam logic [1:0] REG_FRAMES = 2'd3;

  typedef struct packed {
    logic               touched;
    logic               valid;
    logic               dirty;
    logic               refd;
    logic [FRAME_W-1:0] frame;
  } pe_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_PE, ST_HOWN, ST_HP2, ST_HREF,
    ST_VFIFO, ST_VLRU, ST_CLK_INIT, ST_CLK_ORD, ST_CLK_PRD, ST_CLK_TST,
    ST_OPT_RD, ST_OPT_CMP, ST_EV_ORD, ST_EV_PRD, ST_EV_WR, ST_FIN,
    ST_LRU_RD, ST_LRU_A, ST_LRU_B, ST_LRU_C, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_PE_RD, OP_PE_TAKE, OP_HOWN, OP_HP2, OP_HREF,
    OP_VFIFO, OP_VLRU, OP_CLK_INIT, OP_CLK_ORD, OP_CLK_PRD, OP_CLK_TST,
    OP_OPT_RD, OP_OPT_CMP, OP_EV_ORD, OP_EV_PRD, OP_EV_WR, OP_FIN,
    OP_LRU_RD, OP_LRU_A, OP_LRU_B, OP_LRU_C, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic       in_range;
    logic       hit;
    logic       free_avail;
    logic [1:0] policy;
    logic       p2_is_page;
    logic       clk_exh;
    logic       clk_ref;
    logic       opt_stop;
    logic       lru_go;
    logic       lru_rm;
    logic       clear_last;
    logic       out_free;
  } sts_t;

endpackage

### design/paged_translation_with_replacement.sv
// ---------------------------------------------------------------------------
// paged_translation_with_replacement
// Demand-paged address translation with FIFO, LRU, CLOCK or OPT replacement.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request per access; tdata = virtual address and next-use time,
//           tuser = write flag and next-use valid flag.
//   out_* : one result per request; tdata = frame and victim page, tuser =
//           range, fault, compulsory, evicted and write-back flags.
//   cfg_* : APB register port (policy, offset width, page count, frame count);
//           write only while no request is in flight. pready is tied high.
// Flow: an out-of-range request goes straight to its result; a hit under
//   CLOCK also reads the frame's owner entry and sets its reference bit; a
//   fault takes a free frame if one is left, else a victim by FIFO, LRU, OPT
//   (scan of next-use times) or CLOCK (up to two laps); under LRU the list is then updated.
//   One request is worked at a time; the sequencer takes a new one only in
//   its idle state.
// Reset: a clearing pass over all 1024 page entries empties the page table and resets the
//   LRU links and next-use values; in_tready stays low until it is done.
// Stall: a result waits in the output register; the next request is taken
//   but its result holds until the receiver takes the pending one.
// ---------------------------------------------------------------------------
module paged_translation_with_replacement import ptr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,    // [63:0] virtual_address, [95:64] next_use_time
  input  logic [1:0]  in_tuser,    // [0] write_access, [1] next_use_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [5:0] frame_number, [15:6] victim_page
  output logic [4:0]  out_tuser,   // [0] in_range, [1] page_fault, [2] compulsory_miss,
                                   // [3] evicted, [4] write_back
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t cmd;   // sequencer to datapath
  sts_t sts;   // datapath decisions back to sequencer

  ptr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptr_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

endmodule

### design/ptr_ram.sv
// ---------------------------------------------------------------------------
// ptr_ram
// Generic RAM, one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/ptr_ctrl.sv
// ---------------------------------------------------------------------------
// ptr_ctrl
// Sequencer: walks each request through lookup, victim choice and update.
// ---------------------------------------------------------------------------
module ptr_ctrl import ptr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = sts.in_range ? ST_PE : ST_DONE;
      ST_PE: begin
        if (sts.hit) begin
          state_nxt = (sts.policy == POL_CLOCK) ? ST_HOWN : ST_FIN;
        end else if (sts.free_avail) begin
          state_nxt = ST_FIN;
        end else begin
          case (sts.policy)
            POL_FIFO:  state_nxt = ST_VFIFO;
            POL_LRU:   state_nxt = ST_VLRU;
            POL_CLOCK: state_nxt = ST_CLK_INIT;
            default:   state_nxt = ST_OPT_RD;
          endcase
        end
      end
      ST_HOWN:     state_nxt = ST_HP2;
      ST_HP2:      state_nxt = sts.p2_is_page ? ST_FIN : ST_HREF;
      ST_HREF:     state_nxt = ST_FIN;
      ST_VFIFO:    state_nxt = ST_EV_ORD;
      ST_VLRU:     state_nxt = ST_EV_ORD;
      ST_CLK_INIT: state_nxt = ST_CLK_ORD;
      ST_CLK_ORD:  state_nxt = sts.clk_exh ? ST_EV_ORD : ST_CLK_PRD;
      ST_CLK_PRD:  state_nxt = ST_CLK_TST;
      ST_CLK_TST:  state_nxt = sts.clk_ref ? ST_CLK_ORD : ST_EV_ORD;
      ST_OPT_RD:   state_nxt = ST_OPT_CMP;
      ST_OPT_CMP:  state_nxt = sts.opt_stop ? ST_EV_ORD : ST_OPT_RD;
      ST_EV_ORD:   state_nxt = ST_EV_PRD;
      ST_EV_PRD:   state_nxt = ST_EV_WR;
      ST_EV_WR:    state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.lru_go) begin
          state_nxt = sts.lru_rm ? ST_LRU_RD : ST_LRU_B;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LRU_RD:   state_nxt = ST_LRU_A;
      ST_LRU_A:    state_nxt = ST_LRU_B;
      ST_LRU_B:    state_nxt = ST_LRU_C;
      ST_LRU_C:    state_nxt = ST_DONE;
      ST_DONE:     if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    case (state_r)
      ST_CLEAR:    cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_CHECK:    cmd.op = OP_PE_RD;
      ST_PE:       cmd.op = OP_PE_TAKE;
      ST_HOWN:     cmd.op = OP_HOWN;
      ST_HP2:      cmd.op = OP_HP2;
      ST_HREF:     cmd.op = OP_HREF;
      ST_VFIFO:    cmd.op = OP_VFIFO;
      ST_VLRU:     cmd.op = OP_VLRU;
      ST_CLK_INIT: cmd.op = OP_CLK_INIT;
      ST_CLK_ORD:  cmd.op = OP_CLK_ORD;
      ST_CLK_PRD:  cmd.op = OP_CLK_PRD;
      ST_CLK_TST:  cmd.op = OP_CLK_TST;
      ST_OPT_RD:   cmd.op = OP_OPT_RD;
      ST_OPT_CMP:  cmd.op = OP_OPT_CMP;
      ST_EV_ORD:   cmd.op = OP_EV_ORD;
      ST_EV_PRD:   cmd.op = OP_EV_PRD;
      ST_EV_WR:    cmd.op = OP_EV_WR;
      ST_FIN:      cmd.op = OP_FIN;
      ST_LRU_RD:   cmd.op = OP_LRU_RD;
      ST_LRU_A:    cmd.op = OP_LRU_A;
      ST_LRU_B:    cmd.op = OP_LRU_B;
      ST_LRU_C:    cmd.op = OP_LRU_C;
      ST_DONE:     cmd.op = OP_DONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

### design/ptr_dpath.sv
// ---------------------------------------------------------------------------
// ptr_dpath
// Datapath: config registers, page table and frame memories, policy state.
// ---------------------------------------------------------------------------
module ptr_dpath import ptr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [95:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [4:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // config
  logic [1:0]        pol_r, pol_nxt;
  logic [5:0]        off_r, off_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]  fcnt_r, fcnt_nxt;
  // request
  logic [63:0]       va_r, va_nxt;
  logic              wr_r, wr_nxt;
  logic [NU_W-1:0]   nut_r, nut_nxt;
  logic              nuv_r, nuv_nxt;
  // per-request work
  pe_t               pe_r, pe_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic              fault_r, fault_nxt, comp_r, comp_nxt;
  logic              evict_r, evict_nxt, wb_r, wb_nxt;
  logic [PAGE_W-1:0] victim_r, victim_nxt, p2_r, p2_nxt;
  logic              hitref_r, hitref_nxt, lru_rm_r, lru_rm_nxt;
  logic [CNT_W:0]    cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] best_r, best_nxt, oidx_r, oidx_nxt;
  logic [NU_W-1:0]   far_r, far_nxt;
  // policy state
  logic [CNT_W-1:0]  handed_r, handed_nxt;
  logic [FRAME_W-1:0] fifo_r, fifo_nxt, clk_r, clk_nxt;
  logic [LINK_W-1:0] mr_r, mr_nxt, lr_r, lr_nxt;
  logic [PAGE_W-1:0] clr_r, clr_nxt;
  // output slot
  logic              ov_r, ov_nxt;
  logic [15:0]       od_r, od_nxt;
  logic [4:0]        ou_r, ou_nxt;

  // memory ports
  logic              pe_we, own_we, old_we, new_we, nu_we;
  logic [PAGE_W-1:0] pe_waddr, pe_raddr;
  pe_t               pe_wdata, pe_rd;
  logic [FRAME_W-1:0] own_waddr, own_raddr, old_waddr, old_raddr;
  logic [FRAME_W-1:0] new_waddr, new_raddr, nu_waddr, nu_raddr;
  logic [PAGE_W-1:0] own_wdata, own_rd;
  logic [LINK_W-1:0] old_wdata, old_rd, new_wdata, new_rd;
  logic [NU_W-1:0]   nu_wdata, nu_rd;

  ptr_ram #(.WIDTH($bits(pe_t)), .DEPTH(NUM_PAGES)) u_pe (
    .clk(clk), .we(pe_we), .waddr(pe_waddr), .wdata(pe_wdata),
    .raddr(pe_raddr), .rdata(pe_rd)
  );
  ptr_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_FRAMES)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rd)
  );
  ptr_ram #(.WIDTH(LINK_W), .DEPTH(NUM_FRAMES)) u_older (
    .clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
    .raddr(old_raddr), .rdata(old_rd)
  );
  ptr_ram #(.WIDTH(LINK_W), .DEPTH(NUM_FRAMES)) u_newer (
    .clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
    .raddr(new_raddr), .rdata(new_rd)
  );
  ptr_ram #(.WIDTH(NU_W), .DEPTH(NUM_FRAMES)) u_nextuse (
    .clk(clk), .we(nu_we), .waddr(nu_waddr), .wdata(nu_wdata),
    .raddr(nu_raddr), .rdata(nu_rd)
  );

  // derived request values
  logic [63:0]        vpn;
  logic [PCNT_W-1:0]  pc_eff;
  logic [CNT_W-1:0]   nf, nf_a, nf_b;
  logic [PAGE_W-1:0]  page;
  logic               in_range;
  logic [FRAME_W-1:0] fifo_f, clk_inc, fifo_inc;
  logic               nu_ge;
  logic [NU_W-1:0]    far_new;
  logic [FRAME_W-1:0] best_new;
  logic [LINK_W-1:0]  frame_link;
  logic               cfg_wr;

  assign vpn      = va_r >> off_r;
  assign pc_eff   = (pcnt_r > PCNT_W'(NUM_PAGES)) ? PCNT_W'(NUM_PAGES) : pcnt_r;
  assign in_range = (vpn[63:PCNT_W] == '0) && (vpn[PCNT_W-1:0] < pc_eff);
  assign page     = vpn[PAGE_W-1:0];
  assign nf_a     = ({{(PCNT_W-CNT_W){1'b0}}, fcnt_r} > pc_eff) ?
                    pc_eff[CNT_W-1:0] : fcnt_r;
  assign nf_b     = (nf_a > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : nf_a;
  assign nf       = (nf_b == '0) ? CNT_W'(1) : nf_b;

  assign fifo_f   = ({1'b0, fifo_r} < nf) ? fifo_r : '0;
  assign fifo_inc = ({1'b0, fifo_f} + CNT_W'(1) == nf) ? '0 : fifo_f + FRAME_W'(1);
  assign clk_inc  = ({1'b0, clk_r} + CNT_W'(1) == nf) ? '0 : clk_r + FRAME_W'(1);

  assign nu_ge    = nu_rd >= far_r;
  assign far_new  = nu_ge ? nu_rd : far_r;
  assign best_new = nu_ge ? oidx_r : best_r;
  assign frame_link = {1'b0, frame_r};

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_POLICY: cfg_prdata = {30'd0, pol_r};
      REG_OFFSET: cfg_prdata = {26'd0, off_r};
      REG_PAGES:  cfg_prdata = {21'd0, pcnt_r};
      REG_FRAMES: cfg_prdata = {25'd0, fcnt_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    sts.in_range   = in_range;
    sts.hit        = pe_rd.valid;
    sts.free_avail = handed_r < nf;
    sts.policy     = pol_r;
    sts.p2_is_page = own_rd == page;
    sts.clk_exh    = cnt_r == {nf, 1'b0};
    sts.clk_ref    = pe_rd.refd;
    sts.opt_stop   = (far_new == NEVER_USE) || ({1'b0, oidx_r} == nf - CNT_W'(1));
    sts.lru_go     = (pol_r == POL_LRU) && (fault_r || (mr_r != frame_link));
    sts.lru_rm     = lru_rm_r;
    sts.clear_last = clr_r == PAGE_W'(NUM_PAGES - 1);
    sts.out_free   = !ov_r || out_tready;
  end

  always_comb begin
    pol_nxt = pol_r;  off_nxt = off_r;  pcnt_nxt = pcnt_r;  fcnt_nxt = fcnt_r;
    va_nxt = va_r;  wr_nxt = wr_r;  nut_nxt = nut_r;  nuv_nxt = nuv_r;
    pe_nxt = pe_r;  frame_nxt = frame_r;  fault_nxt = fault_r;  comp_nxt = comp_r;
    evict_nxt = evict_r;  wb_nxt = wb_r;  victim_nxt = victim_r;  p2_nxt = p2_r;
    hitref_nxt = hitref_r;  lru_rm_nxt = lru_rm_r;  cnt_nxt = cnt_r;
    best_nxt = best_r;  oidx_nxt = oidx_r;  far_nxt = far_r;
    handed_nxt = handed_r;  fifo_nxt = fifo_r;  clk_nxt = clk_r;
    mr_nxt = mr_r;  lr_nxt = lr_r;  clr_nxt = clr_r;
    ov_nxt = ov_r & ~out_tready;  od_nxt = od_r;  ou_nxt = ou_r;

    pe_we = 1'b0;  pe_waddr = page;  pe_wdata = '0;  pe_raddr = page;
    own_we = 1'b0;  own_waddr = frame_r;  own_wdata = page;  own_raddr = frame_r;
    old_we = 1'b0;  old_waddr = frame_r;  old_wdata = LINK_NONE;  old_raddr = frame_r;
    new_we = 1'b0;  new_waddr = frame_r;  new_wdata = LINK_NONE;  new_raddr = frame_r;
    nu_we = 1'b0;  nu_waddr = frame_r;  nu_wdata = nut_r;  nu_raddr = oidx_r;

    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_POLICY: pol_nxt  = cfg_pwdata[1:0];
        REG_OFFSET: off_nxt  = cfg_pwdata[5:0];
        REG_PAGES:  pcnt_nxt = cfg_pwdata[PCNT_W-1:0];
        REG_FRAMES: fcnt_nxt = cfg_pwdata[CNT_W-1:0];
        default:    pol_nxt  = pol_r;
      endcase
    end

    if (cmd.accept) begin
      va_nxt  = in_tdata[63:0];
      nut_nxt = in_tdata[95:64];
      wr_nxt  = in_tuser[0];
      nuv_nxt = in_tuser[1];
    end

    case (cmd.op)
      OP_CLEAR: begin
        pe_we    = 1'b1;
        pe_waddr = clr_r;
        if (clr_r < PAGE_W'(NUM_FRAMES)) begin
          old_we = 1'b1;  old_waddr = clr_r[FRAME_W-1:0];
          new_we = 1'b1;  new_waddr = clr_r[FRAME_W-1:0];
          nu_we  = 1'b1;  nu_waddr  = clr_r[FRAME_W-1:0];  nu_wdata = NEVER_USE;
        end
        clr_nxt = clr_r + PAGE_W'(1);
      end
      OP_PE_RD: begin
        frame_nxt = '0;  fault_nxt = 1'b0;  comp_nxt = 1'b0;  evict_nxt = 1'b0;
        wb_nxt = 1'b0;  victim_nxt = '0;  hitref_nxt = 1'b0;
      end
      OP_PE_TAKE: begin
        pe_nxt     = pe_rd;
        best_nxt   = '0;  far_nxt = '0;  oidx_nxt = '0;
        lru_rm_nxt = pe_rd.valid | ~sts.free_avail;
        if (pe_rd.valid) begin
          frame_nxt = pe_rd.frame;
        end else begin
          fault_nxt = 1'b1;
          comp_nxt  = ~pe_rd.touched;
          if (sts.free_avail) begin
            frame_nxt  = handed_r[FRAME_W-1:0];
            handed_nxt = handed_r + CNT_W'(1);
          end
        end
      end
      OP_HOWN: own_raddr = frame_r;
      OP_HP2: begin
        p2_nxt     = own_rd;
        pe_raddr   = own_rd;
        hitref_nxt = own_rd == page;
      end
      OP_HREF: begin
        pe_we         = 1'b1;
        pe_waddr      = p2_r;
        pe_wdata      = pe_rd;
        pe_wdata.refd = 1'b1;
      end
      OP_VFIFO: begin
        frame_nxt = fifo_f;
        fifo_nxt  = fifo_inc;
      end
      OP_VLRU: frame_nxt = lr_r[LINK_W-1] ? '0 : lr_r[FRAME_W-1:0];
      OP_CLK_INIT: begin
        if ({1'b0, clk_r} >= nf) clk_nxt = '0;
        cnt_nxt = '0;
      end
      OP_CLK_ORD: begin
        own_raddr = clk_r;
        frame_nxt = clk_r;
        clk_nxt   = clk_inc;
      end
      OP_CLK_PRD: begin
        p2_nxt   = own_rd;
        pe_raddr = own_rd;
      end
      OP_CLK_TST: begin
        if (pe_rd.refd) begin
          pe_we         = 1'b1;
          pe_waddr      = p2_r;
          pe_wdata      = pe_rd;
          pe_wdata.refd = 1'b0;
          cnt_nxt       = cnt_r + (CNT_W+1)'(1);
        end
      end
      OP_OPT_RD: nu_raddr = oidx_r;
      OP_OPT_CMP: begin
        far_nxt   = far_new;
        best_nxt  = best_new;
        frame_nxt = best_new;
        oidx_nxt  = oidx_r + FRAME_W'(1);
      end
      OP_EV_ORD: begin
        own_raddr = frame_r;
        evict_nxt = 1'b1;
      end
      OP_EV_PRD: begin
        victim_nxt = own_rd;
        pe_raddr   = own_rd;
      end
      OP_EV_WR: begin
        wb_nxt           = pe_rd.dirty;
        pe_we            = 1'b1;
        pe_waddr         = victim_r;
        pe_wdata         = '0;
        pe_wdata.touched = pe_rd.touched;
      end
      OP_FIN: begin
        pe_we    = 1'b1;
        pe_waddr = page;
        if (fault_r) begin
          pe_wdata.touched = 1'b1;
          pe_wdata.valid   = 1'b1;
          pe_wdata.dirty   = wr_r;
          pe_wdata.refd    = pol_r == POL_CLOCK;
          pe_wdata.frame   = frame_r;
          own_we    = 1'b1;
          own_waddr = frame_r;
          own_wdata = page;
        end else begin
          pe_wdata         = pe_r;
          pe_wdata.touched = 1'b1;
          pe_wdata.dirty   = pe_r.dirty | wr_r;
          pe_wdata.refd    = pe_r.refd | hitref_r;
        end
        nu_we    = (pol_r == POL_OPT) && nuv_r;
        nu_waddr = frame_r;
        nu_wdata = nut_r;
      end
      OP_LRU_RD: begin
        old_raddr = frame_r;
        new_raddr = frame_r;
      end
      OP_LRU_A: begin
        // unlink: neighbors point past this frame
        old_we    = ~new_rd[LINK_W-1];
        old_waddr = new_rd[FRAME_W-1:0];
        old_wdata = old_rd;
        new_we    = ~old_rd[LINK_W-1];
        new_waddr = old_rd[FRAME_W-1:0];
        new_wdata = new_rd;
        if (new_rd[LINK_W-1]) mr_nxt = old_rd;
        if (old_rd[LINK_W-1]) lr_nxt = new_rd;
      end
      OP_LRU_B: begin
        old_we    = 1'b1;  old_waddr = frame_r;  old_wdata = mr_r;
        new_we    = 1'b1;  new_waddr = frame_r;  new_wdata = LINK_NONE;
      end
      OP_LRU_C: begin
        new_we    = ~mr_r[LINK_W-1];
        new_waddr = mr_r[FRAME_W-1:0];
        new_wdata = frame_link;
        mr_nxt    = frame_link;
        if (lr_r[LINK_W-1]) lr_nxt = frame_link;
      end
      OP_DONE: begin
        if (sts.out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {victim_r, frame_r};
          ou_nxt = {wb_r, evict_r, comp_r, fault_r, in_range};
        end
      end
      default: ov_nxt = ov_r & ~out_tready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r    <= POL_FIFO;
      off_r    <= 6'd12;
      pcnt_r   <= PCNT_W'(NUM_PAGES);
      fcnt_r   <= CNT_W'(NUM_FRAMES);
      handed_r <= '0;
      fifo_r   <= '0;
      clk_r    <= '0;
      mr_r     <= LINK_NONE;
      lr_r     <= LINK_NONE;
      clr_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      pol_r    <= pol_nxt;
      off_r    <= off_nxt;
      pcnt_r   <= pcnt_nxt;
      fcnt_r   <= fcnt_nxt;
      handed_r <= handed_nxt;
      fifo_r   <= fifo_nxt;
      clk_r    <= clk_nxt;
      mr_r     <= mr_nxt;
      lr_r     <= lr_nxt;
      clr_r    <= clr_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r     <= va_nxt;
    wr_r     <= wr_nxt;
    nut_r    <= nut_nxt;
    nuv_r    <= nuv_nxt;
    pe_r     <= pe_nxt;
    frame_r  <= frame_nxt;
    fault_r  <= fault_nxt;
    comp_r   <= comp_nxt;
    evict_r  <= evict_nxt;
    wb_r     <= wb_nxt;
    victim_r <= victim_nxt;
    p2_r     <= p2_nxt;
    hitref_r <= hitref_nxt;
    lru_rm_r <= lru_rm_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    oidx_r   <= oidx_nxt;
    far_r    <= far_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

### design/ptr_checker.sv
// ---------------------------------------------------------------------------
// ptr_checker
// Port-level checks of the page translation block, bound to the top level.
// ---------------------------------------------------------------------------
`include "paged_translation_with_replacement_assert.svh"

module ptr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [4:0]  out_tuser
);

  // stalled result holds
  `PTR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // one request at a time: busy right after an accept
  `PTR_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // out-of-range result carries nothing
  `PTR_ASSERT_NOW(a_oor_zero, out_tvalid && !out_tuser[0], out_tuser[4:1] == 4'd0 && out_tdata == 16'd0, "out-of-range result not empty")

  // eviction, write-back and compulsory miss only on a fault; write-back only with eviction
  `PTR_ASSERT_NOW(a_evict_fault, out_tvalid && (out_tuser[3] || out_tuser[4] || out_tuser[2]), out_tuser[1] && (!out_tuser[4] || out_tuser[3]), "eviction flags inconsistent")

  // victim page zero unless evicted
  `PTR_ASSERT_NOW(a_victim_zero, out_tvalid && !out_tuser[3], out_tdata[15:6] == 10'd0, "victim page without eviction")

endmodule

bind paged_translation_with_replacement ptr_checker u_ptr_checker (.*);
